/* rtl/rational_arithmetic_unit_defines.svh */
// Assertion macros for the rational arithmetic unit checker.
// Used by rau_checker.sv only; no other dependencies.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// plain property, clocked and disabled in reset
`define RAU_ASSERT(lbl, ck, rstn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) \
        else $error("rational arithmetic unit: property failed");

// implication: when the trigger holds, the consequence must hold in the same cycle
`define RAU_ASSERT_IMP(lbl, ck, rstn, trig, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (trig) |-> (cons)) \
        else $error("rational arithmetic unit: implication failed");

// implication checked in the next cycle
`define RAU_ASSERT_NXT(lbl, ck, rstn, trig, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (trig) |=> (cons)) \
        else $error("rational arithmetic unit: next-cycle implication failed");

`endif

/* rtl/rau_pkg.sv */
// Shared constants, codes and controller/datapath interface types
// for the rational arithmetic unit. No dependencies.
package rau_pkg;

    localparam int unsigned WIDTH = 32;
    localparam int unsigned PW    = 2 * WIDTH;
    localparam int unsigned CW    = $clog2(PW);

    // operation codes
    localparam logic [3:0] MODE_ADD = 4'd0;
    localparam logic [3:0] MODE_SUB = 4'd1;
    localparam logic [3:0] MODE_MUL = 4'd2;
    localparam logic [3:0] MODE_DIV = 4'd3;
    localparam logic [3:0] MODE_NEG = 4'd4;
    localparam logic [3:0] MODE_GT  = 4'd5;
    localparam logic [3:0] MODE_LT  = 4'd6;
    localparam logic [3:0] MODE_GE  = 4'd7;
    localparam logic [3:0] MODE_LE  = 4'd8;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIVZERO  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // multiplier operand pairs
    localparam logic [1:0] MS_LN_RD = 2'd0;
    localparam logic [1:0] MS_RN_LD = 2'd1;
    localparam logic [1:0] MS_LD_RD = 2'd2;
    localparam logic [1:0] MS_LN_RN = 2'd3;

    // product destinations
    localparam logic [1:0] MD_PA = 2'd0;
    localparam logic [1:0] MD_PB = 2'd1;
    localparam logic [1:0] MD_PD = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic [1:0] mul_dst;
        logic       comb;
        logic       gcd_step;
        logic       gscale;
        logic       div_step;
        logic       div_reload;
        logic       fin;
    } cmd_t;

    typedef struct packed {
        logic [3:0] mode;
        logic       rn_zero;
        logic       gcd_done;
        logic       div_last;
    } sts_t;

endpackage

/* rtl/rau_datapath.sv */
// Datapath of the rational arithmetic unit: operand registers, shared
// multiplier, binary gcd, shared restoring divider and result registers.
// Depends on rau_pkg.
module rau_datapath (
    input  logic                clk,
    input  rau_pkg::cmd_t       cmd,
    output rau_pkg::sts_t       sts,
    input  logic [3:0]          mode,
    input  logic signed [31:0]  lhs_num,
    input  logic signed [31:0]  lhs_den,
    input  logic signed [31:0]  rhs_num,
    input  logic signed [31:0]  rhs_den,
    output logic signed [31:0]  res_num,
    output logic signed [31:0]  res_den,
    output logic                compare_flag,
    output logic [1:0]          status
);

    localparam int unsigned W  = rau_pkg::WIDTH;
    localparam int unsigned PW = rau_pkg::PW;
    localparam int unsigned CW = rau_pkg::CW;

    logic [3:0]          mode_reg;
    logic signed [W-1:0] ln_reg, ld_reg, rn_reg, rd_reg;
    logic [PW-1:0]       pa_mag_reg, pb_mag_reg, pd_mag_reg;
    logic                pa_neg_reg, pb_neg_reg, pd_neg_reg;
    logic [PW-1:0]       n_mag_reg, d_mag_reg;
    logic                n_neg_reg, d_neg_reg;
    logic [PW-1:0]       ga_reg, gb_reg, g_reg;
    logic [CW-1:0]       gk_reg;
    logic                gz_reg;
    logic [PW-1:0]       quo_reg, rem_reg, qn_reg;
    logic [CW-1:0]       cnt_reg;
    logic signed [W-1:0] res_num_reg, res_den_reg;
    logic                flag_reg;
    logic [1:0]          status_reg;

    // operand registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            ln_reg   <= lhs_num;
            ld_reg   <= lhs_den;
            rn_reg   <= rhs_num;
            rd_reg   <= rhs_den;
        end
    end

    // shared sign-magnitude multiplier
    logic signed [W-1:0] ma, mb;
    logic [W-1:0]        ma_mag, mb_mag;
    logic [PW-1:0]       prod;
    logic                prod_neg;

    always_comb
    begin
        unique case (cmd.mul_sel)
            rau_pkg::MS_LN_RD: begin ma = ln_reg; mb = rd_reg; end
            rau_pkg::MS_RN_LD: begin ma = rn_reg; mb = ld_reg; end
            rau_pkg::MS_LD_RD: begin ma = ld_reg; mb = rd_reg; end
            default:           begin ma = ln_reg; mb = rn_reg; end
        endcase
        ma_mag   = ma[W-1] ? W'(-ma) : W'(ma);
        mb_mag   = mb[W-1] ? W'(-mb) : W'(mb);
        prod     = PW'(ma_mag) * PW'(mb_mag);
        prod_neg = (ma[W-1] ^ mb[W-1]) && (prod != '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            unique case (cmd.mul_dst)
                rau_pkg::MD_PA: begin pa_mag_reg <= prod; pa_neg_reg <= prod_neg; end
                rau_pkg::MD_PB: begin pb_mag_reg <= prod; pb_neg_reg <= prod_neg; end
                default:        begin pd_mag_reg <= prod; pd_neg_reg <= prod_neg; end
            endcase
        end
    end

    // numerator: sum or difference of the cross products, else the first product
    logic          fb_neg;
    logic [PW-1:0] sum_mag;
    logic          sum_neg;

    always_comb
    begin
        fb_neg = (mode_reg == rau_pkg::MODE_SUB) ? (!pb_neg_reg && (pb_mag_reg != '0))
                                                 : pb_neg_reg;
        if (pa_neg_reg == fb_neg)
        begin
            sum_mag = pa_mag_reg + pb_mag_reg;
            sum_neg = pa_neg_reg;
        end
        else if (pa_mag_reg >= pb_mag_reg)
        begin
            sum_mag = pa_mag_reg - pb_mag_reg;
            sum_neg = pa_neg_reg;
        end
        else
        begin
            sum_mag = pb_mag_reg - pa_mag_reg;
            sum_neg = fb_neg;
        end
        if (sum_mag == '0)
            sum_neg = 1'b0;
        if (mode_reg != rau_pkg::MODE_ADD && mode_reg != rau_pkg::MODE_SUB)
        begin
            sum_mag = pa_mag_reg;
            sum_neg = pa_neg_reg;
        end
    end

    // binary gcd, one step a cycle
    logic [PW-1:0] ga_next, gb_next;
    logic [CW-1:0] gk_next;

    always_comb
    begin
        ga_next = ga_reg;
        gb_next = gb_reg;
        gk_next = gk_reg;
        priority if (!ga_reg[0] && !gb_reg[0])
        begin
            ga_next = ga_reg >> 1;
            gb_next = gb_reg >> 1;
            gk_next = gk_reg + CW'(1);
        end
        else if (!ga_reg[0])
            ga_next = ga_reg >> 1;
        else if (!gb_reg[0])
            gb_next = gb_reg >> 1;
        else if (ga_reg > gb_reg)
            ga_next = ga_reg - gb_reg;
        else
            gb_next = gb_reg - ga_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.comb)
        begin
            n_mag_reg <= sum_mag;
            n_neg_reg <= sum_neg;
            d_mag_reg <= pd_mag_reg;
            d_neg_reg <= pd_neg_reg;
            ga_reg    <= sum_mag;
            gb_reg    <= pd_mag_reg;
            gk_reg    <= '0;
            gz_reg    <= (sum_mag == '0) || (pd_mag_reg == '0);
        end
        else if (cmd.gcd_step)
        begin
            ga_reg <= ga_next;
            gb_reg <= gb_next;
            gk_reg <= gk_next;
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [PW:0]   rem_sh, diff;
    logic [PW-1:0] rem_next, quo_next;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[PW-1]};
        diff   = rem_sh - {1'b0, g_reg};
        if (!diff[PW])
        begin
            rem_next = diff[PW-1:0];
            quo_next = {quo_reg[PW-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh[PW-1:0];
            quo_next = {quo_reg[PW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.gscale)
        begin
            g_reg   <= gz_reg ? PW'(1) : (ga_reg << gk_reg);
            quo_reg <= n_mag_reg;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_reload)
        begin
            qn_reg  <= quo_reg;
            quo_reg <= d_mag_reg;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    // result assembly
    logic signed [PW-1:0] pv, qv;
    logic                 fl;
    logic                 f_neg;
    logic [PW-1:0]        f_den;
    logic                 fits;
    logic signed [W-1:0]  r_num, r_den;
    logic                 r_flag;
    logic [1:0]           r_st;

    always_comb
    begin
        pv = pa_neg_reg ? $signed(-pa_mag_reg) : $signed(pa_mag_reg);
        qv = pb_neg_reg ? $signed(-pb_mag_reg) : $signed(pb_mag_reg);
        unique case (mode_reg)
            rau_pkg::MODE_GT: fl = pv >  qv;
            rau_pkg::MODE_LT: fl = pv <  qv;
            rau_pkg::MODE_GE: fl = pv >= qv;
            default:          fl = pv <= qv;
        endcase

        f_neg = (n_neg_reg != d_neg_reg) && (qn_reg != '0);
        f_den = (qn_reg == '0) ? PW'(1) : quo_reg;
        fits  = (f_neg ? (qn_reg <= (PW'(1) << (W - 1))) : (qn_reg < (PW'(1) << (W - 1))))
                && (f_den < (PW'(1) << (W - 1)));

        r_num  = '0;
        r_den  = W'(1);
        r_flag = 1'b0;
        r_st   = rau_pkg::ST_OK;
        priority if (mode_reg >= rau_pkg::MODE_GT && mode_reg <= rau_pkg::MODE_LE)
            r_flag = fl;
        else if (mode_reg > rau_pkg::MODE_LE)
            r_st = rau_pkg::ST_OK;
        else if (mode_reg == rau_pkg::MODE_NEG)
        begin
            if (ln_reg == {1'b1, {(W - 1){1'b0}}})
                r_st = rau_pkg::ST_OVERFLOW;
            else
            begin
                r_num = -ln_reg;
                r_den = ld_reg;
            end
        end
        else if (mode_reg == rau_pkg::MODE_DIV && rn_reg == '0)
            r_st = rau_pkg::ST_DIVZERO;
        else if (!fits)
            r_st = rau_pkg::ST_OVERFLOW;
        else
        begin
            r_num = f_neg ? -$signed(qn_reg[W-1:0]) : $signed(qn_reg[W-1:0]);
            r_den = $signed(f_den[W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            res_num_reg <= r_num;
            res_den_reg <= r_den;
            flag_reg    <= r_flag;
            status_reg  <= r_st;
        end
    end

    assign res_num      = res_num_reg;
    assign res_den      = res_den_reg;
    assign compare_flag = flag_reg;
    assign status       = status_reg;

    // status to the controller
    assign sts.mode     = mode_reg;
    assign sts.rn_zero  = (rn_reg == '0);
    assign sts.gcd_done = gz_reg || (ga_reg == gb_reg);
    assign sts.div_last = (cnt_reg == {CW{1'b1}});

endmodule

/* rtl/rau_ctrl.sv */
// Controller of the rational arithmetic unit: sequences multiply, gcd
// and divide steps and owns the handshakes. Depends on rau_pkg.
module rau_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output rau_pkg::cmd_t cmd,
    input  rau_pkg::sts_t sts
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL0   = 4'd1;
    localparam logic [3:0] S_MUL1   = 4'd2;
    localparam logic [3:0] S_MUL2   = 4'd3;
    localparam logic [3:0] S_COMB   = 4'd4;
    localparam logic [3:0] S_GCD    = 4'd5;
    localparam logic [3:0] S_GSCALE = 4'd6;
    localparam logic [3:0] S_DIVN   = 4'd7;
    localparam logic [3:0] S_RELOAD = 4'd8;
    localparam logic [3:0] S_DIVD   = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       is_addsub, is_mul, is_div, is_cmp, is_fast;

    // operation classes
    always_comb
    begin
        is_addsub = (sts.mode == rau_pkg::MODE_ADD) || (sts.mode == rau_pkg::MODE_SUB);
        is_mul    = (sts.mode == rau_pkg::MODE_MUL);
        is_div    = (sts.mode == rau_pkg::MODE_DIV) && !sts.rn_zero;
        is_cmp    = (sts.mode >= rau_pkg::MODE_GT) && (sts.mode <= rau_pkg::MODE_LE);
        is_fast   = !(is_addsub || is_mul || is_div || is_cmp);
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = is_mul ? rau_pkg::MS_LN_RN : rau_pkg::MS_LN_RD;
                cmd.mul_dst = rau_pkg::MD_PA;
                state_next  = is_fast ? S_FIN : S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_en = 1'b1;
                priority if (is_mul)
                begin
                    cmd.mul_sel = rau_pkg::MS_LD_RD;
                    cmd.mul_dst = rau_pkg::MD_PD;
                    state_next  = S_COMB;
                end
                else if (is_div)
                begin
                    cmd.mul_sel = rau_pkg::MS_RN_LD;
                    cmd.mul_dst = rau_pkg::MD_PD;
                    state_next  = S_COMB;
                end
                else
                begin
                    cmd.mul_sel = rau_pkg::MS_RN_LD;
                    cmd.mul_dst = rau_pkg::MD_PB;
                    state_next  = is_cmp ? S_FIN : S_MUL2;
                end
            end
            S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rau_pkg::MS_LD_RD;
                cmd.mul_dst = rau_pkg::MD_PD;
                state_next  = S_COMB;
            end
            S_COMB:
            begin
                cmd.comb   = 1'b1;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                if (sts.gcd_done)
                    state_next = S_GSCALE;
                else
                    cmd.gcd_step = 1'b1;
            end
            S_GSCALE:
            begin
                cmd.gscale = 1'b1;
                state_next = S_DIVN;
            end
            S_DIVN:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_RELOAD;
            end
            S_RELOAD:
            begin
                cmd.div_reload = 1'b1;
                state_next     = S_DIVD;
            end
            S_DIVD:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                // wait while the previous result is still held
                if (!(out_valid_reg && out_stall))
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.fin)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit: controller plus datapath.
// Depends on rau_pkg, rau_ctrl and rau_datapath.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_stall, mode, lhs_*, rhs_*     | request
//  out     | out_valid, out_stall, res_*, compare_flag, | result
//          | status                                     |
//
// Negate, unknown modes and divide by zero go from the first multiply state straight to the result;
// comparisons after both cross products. Add/sub/mul/div take longer, set by the binary gcd
// loop (one step a cycle) and two passes of the shared divider.
// One item at a time; a new item is taken while the last result waits.
// Asynchronous active-low reset; no clearing pass. A stalled result holds.
module rational_arithmetic_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         mode,
    input  logic signed [31:0] lhs_num,
    input  logic signed [31:0] lhs_den,
    input  logic signed [31:0] rhs_num,
    input  logic signed [31:0] rhs_den,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] res_num,
    output logic signed [31:0] res_den,
    output logic               compare_flag,
    output logic [1:0]         status
);

    rau_pkg::cmd_t cmd;
    rau_pkg::sts_t sts;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    rau_datapath u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (mode),
        .lhs_num      (lhs_num),
        .lhs_den      (lhs_den),
        .rhs_num      (rhs_num),
        .rhs_den      (rhs_den),
        .res_num      (res_num),
        .res_den      (res_den),
        .compare_flag (compare_flag),
        .status       (status)
    );

endmodule

/* rtl/rau_checker.sv */
// Port-level checker for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg and rational_arithmetic_unit_defines.svh.
`include "rational_arithmetic_unit_defines.svh"

module rau_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] res_num,
    input logic signed [31:0] res_den,
    input logic               compare_flag,
    input logic [1:0]         status
);

    logic res_unit;
    logic err_res;
    logic cmp_res;

    // result shapes
    assign res_unit = (res_num == 32'sd0) && (res_den == 32'sd1);
    assign err_res  = out_valid && (status != rau_pkg::ST_OK);
    assign cmp_res  = out_valid && compare_flag;

    // no reserved status code
    `RAU_ASSERT(a_status_code, clk, rst_n, !out_valid || status <= rau_pkg::ST_OVERFLOW)
    // an error result is always 0/1
    `RAU_ASSERT_IMP(a_err_zero, clk, rst_n, err_res, res_unit && !compare_flag)
    // a true comparison carries 0/1 and no error
    `RAU_ASSERT_IMP(a_cmp_clean, clk, rst_n, cmp_res, status == rau_pkg::ST_OK && res_unit)
    // one item at a time: busy after taking an item
    `RAU_ASSERT_NXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall)
    // a stalled result holds
    `RAU_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(res_num) && $stable(res_den))

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .res_num      (res_num),
    .res_den      (res_den),
    .compare_flag (compare_flag),
    .status       (status)
);

/* dv/tb_rational_arithmetic_unit.sv */
// Self-checking testbench for the rational arithmetic unit: directed table, then random items.
// Depends on rau_pkg and rational_arithmetic_unit.
module tb_rational_arithmetic_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] ln;
        logic signed [31:0] ld;
        logic signed [31:0] rn;
        logic signed [31:0] rd;
    } req_t;

    typedef struct packed {
        logic signed [31:0] num;
        logic signed [31:0] den;
        logic               flag;
        logic [1:0]         st;
        logic               fixed;  // expected value typed in the table
    } res_t;

    localparam int N_RAND = 1400;
    localparam int LIMIT  = 2_000_000;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [3:0]         mode;
    logic signed [31:0] lhs_num;
    logic signed [31:0] lhs_den;
    logic signed [31:0] rhs_num;
    logic signed [31:0] rhs_den;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic               compare_flag;
    logic [1:0]         status;

    res_t results_due[$];
    int   errors = 0;
    int   cycles = 0;
    bit   quiet_tail = 1'b0;
    int   hold_req = 0;   // raised by the sender to ask for a long hold-off

    rational_arithmetic_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .lhs_num      (lhs_num),
        .lhs_den      (lhs_den),
        .rhs_num      (rhs_num),
        .rhs_den      (rhs_den),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .res_num      (res_num),
        .res_den      (res_den),
        .compare_flag (compare_flag),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [63:0] mag_of(input logic signed [63:0] x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    // reduced fraction from sign-magnitude numerator and denominator
    function automatic res_t reduce_frac(input logic [63:0] nm, input bit nn,
                                         input logic [63:0] dm, input bit dn);
        res_t r;
        logic [63:0] a, b, t;
        bit neg;
        r = '0;
        a = nm;
        b = dm;
        if (a != 0 && b != 0)
        begin
            while (b != 0)
            begin
                t = a % b;
                a = b;
                b = t;
            end
            nm = nm / a;
            dm = dm / a;
        end
        // a zero denominator carries no sign
        neg = (nn != (dn && dm != 0)) && nm != 0;
        if (nm == 0)
            dm = 1;
        if ((neg ? nm > 64'h8000_0000 : nm >= 64'h8000_0000) || dm >= 64'h8000_0000)
        begin
            r.den = 1;
            r.st = rau_pkg::ST_OVERFLOW;
        end
        else
        begin
            r.num = neg ? -nm[31:0] : nm[31:0];
            r.den = dm[31:0];
            r.st = rau_pkg::ST_OK;
        end
        return r;
    endfunction

    // expected result of one request
    function automatic res_t rational_result(input req_t q);
        res_t r;
        logic signed [63:0] p, s;
        logic signed [64:0] n;
        logic [63:0] nm;
        r = '0;
        r.den = 1;
        unique case (q.mode)
            rau_pkg::MODE_GT, rau_pkg::MODE_LT, rau_pkg::MODE_GE, rau_pkg::MODE_LE:
            begin
                p = 64'(q.ln) * 64'(q.rd);
                s = 64'(q.ld) * 64'(q.rn);
                r.flag = q.mode == rau_pkg::MODE_GT ? p > s :
                         q.mode == rau_pkg::MODE_LT ? p < s :
                         q.mode == rau_pkg::MODE_GE ? p >= s : p <= s;
            end
            rau_pkg::MODE_NEG:
            begin
                if (q.ln == MINV)
                    r.st = rau_pkg::ST_OVERFLOW;
                else
                begin
                    r.num = -q.ln;
                    r.den = q.ld;
                end
            end
            rau_pkg::MODE_ADD, rau_pkg::MODE_SUB:
            begin
                p = 64'(q.ln) * 64'(q.rd);
                s = 64'(q.rn) * 64'(q.ld);
                n = q.mode == rau_pkg::MODE_ADD ? 65'(p) + 65'(s) : 65'(p) - 65'(s);
                nm = n < 0 ? 64'(-n) : 64'(n);
                r = reduce_frac(nm, n < 0, mag_of(64'(q.ld) * 64'(q.rd)),
                                (q.ld < 0) != (q.rd < 0));
            end
            rau_pkg::MODE_MUL:
                r = reduce_frac(mag_of(64'(q.ln) * 64'(q.rn)), (q.ln < 0) != (q.rn < 0),
                                mag_of(64'(q.ld) * 64'(q.rd)), (q.ld < 0) != (q.rd < 0));
            rau_pkg::MODE_DIV:
            begin
                if (q.rn == 0)
                    r.st = rau_pkg::ST_DIVZERO;
                else
                    r = reduce_frac(mag_of(64'(q.ln) * 64'(q.rd)),
                                    (q.ln < 0) != (q.rd < 0),
                                    mag_of(64'(q.ld) * 64'(q.rn)),
                                    (q.ld < 0) != (q.rn < 0));
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3) == 0 ? MINV : MAXV;
            1: return 32'($urandom_range(0, 40)) - 20;
            2: return 32'($urandom_range(0, 2000)) - 1000;
            3: return 32'($urandom_range(0, 200000)) - 100000;
            default: return $urandom;
        endcase
    endfunction

    // directed rows; fixed ones carry their expected value
    req_t dir_req[$];
    res_t dir_res[$];

    task automatic add_row(input logic [3:0] m, input logic signed [31:0] a, b, c, d,
                           input bit fx, input logic signed [31:0] en, ed,
                           input logic fl, input logic [1:0] es);
        req_t q;
        res_t r;
        q = '{m, a, b, c, d};
        r = '{en, ed, fl, es, fx};
        dir_req.push_back(q);
        dir_res.push_back(r);
    endtask

    // one item: optional idle gap, then hold the item until it is taken
    task automatic send_item(input req_t q, input res_t fixed_res, input bit gaps);
        res_t e;
        int g;
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            g = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= q.mode;
        lhs_num  <= q.ln;
        lhs_den  <= q.ld;
        rhs_num  <= q.rn;
        rhs_den  <= q.rd;
        e = rational_result(q);
        if (fixed_res.fixed)
            e = fixed_res;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        results_due.push_back(e);
        @(negedge clk);
    endtask

    // receiver stall bursts and one long hold-off
    initial
    begin
        int hold_done;
        hold_done = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_done)
            begin
                out_stall <= 1'b1;
                for (int k = 0; k < 3000; k++)
                    @(negedge clk);
                out_stall <= 1'b0;
                hold_done = hold_req;
            end
            else if (!quiet_tail && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                $display("%t unexpected result: expected none, got %0d/%0d",
                         $realtime, res_num, res_den);
                errors++;
            end
            else
            begin
                e = results_due.pop_front();
                if (res_num !== e.num || res_den !== e.den || compare_flag !== e.flag
                    || status !== e.st)
                begin
                    $display("%t mismatch: expected %0d/%0d flag %0d status %0d,",
                             $realtime, e.num, e.den, e.flag, e.st);
                    $display("    got %0d/%0d flag %0d status %0d",
                             res_num, res_den, compare_flag, status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        req_t q;
        res_t none;
        int w;
        none = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = rau_pkg::MODE_ADD;
        lhs_num = 0;
        lhs_den = 1;
        rhs_num = 0;
        rhs_den = 1;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed part
        add_row(rau_pkg::MODE_ADD, 1, 2, 1, 3, 1, 5, 6, 0, rau_pkg::ST_OK);
        add_row(rau_pkg::MODE_SUB, 1, 2, 1, 3, 1, 1, 6, 0, rau_pkg::ST_OK);
        add_row(rau_pkg::MODE_SUB, 1, 3, 1, 2, 1, -1, 6, 0, rau_pkg::ST_OK);
        add_row(rau_pkg::MODE_MUL, 2, 3, -3, 4, 1, -1, 2, 0, rau_pkg::ST_OK);
        add_row(rau_pkg::MODE_DIV, 1, 2, 0, 5, 1, 0, 1, 0, rau_pkg::ST_DIVZERO);
        add_row(rau_pkg::MODE_DIV, 3, -4, 6, 8, 1, -1, 1, 0, rau_pkg::ST_OK);
        add_row(rau_pkg::MODE_NEG, 5, 7, 0, 0, 1, -5, 7, 0, rau_pkg::ST_OK);
        add_row(rau_pkg::MODE_NEG, MINV, 1, 0, 0, 1, 0, 1, 0, rau_pkg::ST_OVERFLOW);
        add_row(rau_pkg::MODE_NEG, MAXV, MINV, 0, 0, 1, -MAXV, MINV, 0, rau_pkg::ST_OK);
        add_row(rau_pkg::MODE_NEG, 0, -3, 0, 0, 1, 0, -3, 0, rau_pkg::ST_OK);
        add_row(rau_pkg::MODE_GT, 1, 2, 1, 3, 1, 0, 1, 1, rau_pkg::ST_OK);
        add_row(rau_pkg::MODE_LT, 1, 2, 1, 3, 1, 0, 1, 0, rau_pkg::ST_OK);
        add_row(rau_pkg::MODE_GE, 1, 2, 2, 4, 1, 0, 1, 1, rau_pkg::ST_OK);
        add_row(rau_pkg::MODE_LE, 1, 2, 2, 4, 1, 0, 1, 1, rau_pkg::ST_OK);
        add_row(4'd9, 5, 5, 5, 5, 1, 0, 1, 0, rau_pkg::ST_OK);
        add_row(4'd15, -1, -1, -1, -1, 1, 0, 1, 0, rau_pkg::ST_OK);
        add_row(rau_pkg::MODE_MUL, 0, 5, 7, 9, 1, 0, 1, 0, rau_pkg::ST_OK);
        add_row(rau_pkg::MODE_MUL, 3, 0, 1, 5, 1, 3, 0, 0, rau_pkg::ST_OK);
        add_row(rau_pkg::MODE_MUL, MAXV, 1, MAXV, 1, 1, 0, 1, 0, rau_pkg::ST_OVERFLOW);
        add_row(rau_pkg::MODE_MUL, MINV, 1, -1, 1, 1, 0, 1, 0, rau_pkg::ST_OVERFLOW);
        add_row(rau_pkg::MODE_ADD, MINV, MINV, MAXV, MAXV, 0, 0, 0, 0, rau_pkg::ST_OK);
        add_row(rau_pkg::MODE_SUB, MINV, MAXV, MAXV, MINV, 0, 0, 0, 0, rau_pkg::ST_OK);
        add_row(rau_pkg::MODE_DIV, MINV, -1, MINV, -1, 0, 0, 0, 0, rau_pkg::ST_OK);
        add_row(rau_pkg::MODE_GT, MINV, MINV, MAXV, MINV, 0, 0, 0, 0, rau_pkg::ST_OK);
        add_row(rau_pkg::MODE_LE, -1, MAXV, MINV, -1, 0, 0, 0, 0, rau_pkg::ST_OK);
        foreach (dir_req[i])
            send_item(dir_req[i], dir_res[i], 1);

        // random part
        for (int i = 0; i < N_RAND; i++)
        begin
            q.mode = $urandom_range(0, 19) == 0 ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, 8));
            q.ln = rand_operand();
            q.ld = rand_operand();
            q.rn = rand_operand();
            q.rd = rand_operand();
            if (i == 300)
                hold_req = hold_req + 1;
            if (i == 320)
            begin
                // sender pauses until every result is back
                in_valid <= 1'b0;
                @(negedge clk);
                w = 0;
                while (results_due.size() != 0 && w < 100000)
                begin
                    @(negedge clk);
                    w++;
                end
            end
            if (i == N_RAND - 150)
                quiet_tail = 1'b1;
            send_item(q, none, !quiet_tail);
        end

        // drain
        in_valid <= 1'b0;
        w = 0;
        while (results_due.size() != 0 && w < 200000)
        begin
            @(negedge clk);
            w++;
        end
        repeat (400) @(negedge clk);
        if (errors == 0 && results_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
